>>> src/bske_pkg.sv
// Shared constants for the B-spline kernel evaluator.
`default_nettype none
package bske_pkg;

	localparam int POS_W = 20;
	localparam int KV_W  = 18;
	localparam int SW_W  = 3;
	localparam int CFG_W = 2;

	localparam int KV_MAX = 131071;
	localparam int KV_MIN = -131072;

	// register indexes
	localparam logic REG_DEGREE = 1'b0;
	localparam logic REG_ORDER  = 1'b1;

	// degree codes
	localparam logic [1:0] DEG_HAAR   = 2'd0;
	localparam logic [1:0] DEG_LINEAR = 2'd1;
	localparam logic [1:0] DEG_QUAD   = 2'd2;
	localparam logic [1:0] DEG_CUBIC  = 2'd3;

	// order codes
	localparam logic [1:0] ORD_VALUE = 2'd0;
	localparam logic [1:0] ORD_D1    = 2'd1;
	localparam logic [1:0] ORD_D2    = 2'd2;
	localparam logic [1:0] ORD_NONE  = 2'd3;

	localparam logic [1:0] DEG_RESET = DEG_CUBIC;
	localparam logic [1:0] ORD_RESET = ORD_VALUE;

endpackage
`default_nettype wire

>>> src/bspline_kernel_eval.sv
// Centered B-spline kernel evaluator, degrees 0 to 3 with derivatives.
//
// Usage:
//   s_axis carries one position per transfer (signed, FRAC_BITS fraction bits).
//   m_axis returns one result per input: kernel value, support width, and in
//   tuser a flag for degree/order combinations that have no definition.
//   The cfg port sets degree (index 0) and derivative order (index 1); write
//   it only while no item is in flight.
// Throughput: one item per cycle while m_axis_tready stays high.
// Pipeline: the depth is set by the cubic term a*a*a (two registered
//   multipliers), the wide numerator add, and the divide by three done as
//   a reciprocal multiply.
// Reset: all stage valid bits clear; degree resets to 3, order to 0.
// Stall: when m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops in the same cycle; nothing is lost or
//   repeated, and bubbles in the pipe are not squeezed out.
`default_nettype none
module bspline_kernel_eval #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [bske_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// [19:0] position, [23:20] zero
	input  wire logic [23:0]                s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// [17:0] kernel_value, [20:18] support_width, [23:21] zero
	output logic [23:0]                     m_axis_tdata,
	// [0] unsupported
	output logic                            m_axis_tuser
);
	import bske_pkg::*;

	localparam int F    = FRAC_BITS;
	localparam int AC_W = (F + 2 < 20) ? F + 2 : 20;
	localparam int TW   = (F < 20) ? F : 20;
	localparam int NW   = 3 * F + 8;
	localparam int RW   = (F + 3 > 22) ? F + 3 : 22;
	localparam int QW   = F + 3;
	localparam int DK   = QW + 1;
	localparam int PW   = QW + DK;

	localparam logic [DK-1:0] DIV3_M = DK'(((64'd1 << DK) + 64'd2) / 64'd3);

	localparam logic [31:0] HALF_C  = 32'd1 << (F - 1);
	localparam logic [31:0] ONE_C   = 32'd1 << F;
	localparam logic [31:0] HALF3_C = HALF_C * 32'd3;
	localparam logic [31:0] TWO_C   = 32'd1 << (F + 1);

	localparam logic [NW-1:0] UNIT_N = {{(NW - 1){1'b0}}, 1'b1};
	localparam logic signed [NW-1:0] ONE_N   = UNIT_N << F;
	localparam logic signed [NW-1:0] TWO_N   = UNIT_N << (F + 1);
	localparam logic signed [NW-1:0] HALF3_N = (UNIT_N << (F - 1)) * 3;
	localparam logic signed [NW-1:0] ONESQ_N = UNIT_N << (2 * F);
	localparam logic signed [NW-1:0] ONECU_N = UNIT_N << (3 * F);

	localparam logic signed [RW-1:0] KV_MAX_R = RW'(KV_MAX);
	localparam logic signed [RW-1:0] KV_MIN_R = RW'(KV_MIN);

	logic adv;

	logic [1:0] spline_degree_q, derivative_order_q;

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [POS_W-1:0] x_s1;
	logic [1:0]              deg_s1, deg_s2, deg_s3, deg_s4, deg_s5, deg_s6, deg_s7;
	logic [1:0]              ord_s1, ord_s2, ord_s3, ord_s4;
	logic                    bad_s1, bad_s2, bad_s3, bad_s4, bad_s5, bad_s6, bad_s7;

	logic [AC_W-1:0]   a_s2, a_s3, a_s4;
	logic              pos_s2, pos_s3, pos_s4;
	logic              gt_half_s2, gt_half_s3, gt_half_s4;
	logic              gt_one_s2, gt_one_s3, gt_one_s4, gt_one_s5;
	logic              gt_3half_s2, gt_3half_s3, gt_3half_s4;
	logic              gt_two_s2, gt_two_s3, gt_two_s4;
	logic [2*AC_W-1:0] a_sq_s3, a_sq_s4;
	logic [3*AC_W-1:0] a_cu_s4;
	logic [TW-1:0]     t_s3, t_s4;
	logic [2*TW-1:0]   t_sq_s4;
	logic [3*TW-1:0]   t_cu_s5;

	logic signed [RW-1:0] lin_s5, lin_s6, lin_s7;
	logic [QW-1:0]        q_in_s5, q_s6;
	logic                 use_div_s5, use_div_s6, use_div_s7;
	logic [PW-1:0]        prod_s7;

	logic [KV_W-1:0] kv_s8;
	logic [SW_W-1:0] sw_s8;
	logic            bad_s8;

	// one enable for the whole pipe: move when the output slot frees up
	assign adv           = !v_s8 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spline_degree_q    <= DEG_RESET;
			derivative_order_q <= ORD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEGREE: spline_degree_q    <= cfg_data;
				REG_ORDER:  derivative_order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: capture position and decode the configuration
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= $signed(s_axis_tdata[POS_W-1:0]);
			deg_s1 <= spline_degree_q;
			ord_s1 <= derivative_order_q;
			bad_s1 <= (derivative_order_q == ORD_NONE) ||
			          (spline_degree_q == DEG_HAAR && derivative_order_q != ORD_VALUE) ||
			          (spline_degree_q == DEG_LINEAR && derivative_order_q == ORD_D2);
		end
	end

	// stage 2: magnitude, region compares, clamp to the widest support
	logic signed [POS_W:0] x_ext;
	logic [POS_W:0]        a_full;
	logic [31:0]           a32;
	logic                  gt_two_c;

	always_comb begin
		x_ext    = {x_s1[POS_W-1], x_s1};
		a_full   = x_s1[POS_W-1] ? -x_ext : x_ext;
		a32      = 32'(a_full);
		gt_two_c = a32 > TWO_C;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2        <= gt_two_c ? TWO_C[AC_W-1:0] : a32[AC_W-1:0];
			pos_s2      <= !x_s1[POS_W-1] && (x_s1 != '0);
			gt_half_s2  <= a32 > HALF_C;
			gt_one_s2   <= a32 > ONE_C;
			gt_3half_s2 <= a32 > HALF3_C;
			gt_two_s2   <= gt_two_c;
			deg_s2      <= deg_s1;
			ord_s2      <= ord_s1;
			bad_s2      <= bad_s1;
		end
	end

	// stage 3: a squared, distance to the outer knot
	logic [31:0] t32;

	always_comb begin
		if (deg_s2 == DEG_QUAD) t32 = HALF3_C - 32'(a_s2);
		else                    t32 = TWO_C - 32'(a_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3        <= a_s2;
			a_sq_s3     <= (2 * AC_W)'(a_s2) * (2 * AC_W)'(a_s2);
			t_s3        <= t32[TW-1:0];
			pos_s3      <= pos_s2;
			gt_half_s3  <= gt_half_s2;
			gt_one_s3   <= gt_one_s2;
			gt_3half_s3 <= gt_3half_s2;
			gt_two_s3   <= gt_two_s2;
			deg_s3      <= deg_s2;
			ord_s3      <= ord_s2;
			bad_s3      <= bad_s2;
		end
	end

	// stage 4: a cubed, t squared
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4        <= a_s3;
			a_sq_s4     <= a_sq_s3;
			a_cu_s4     <= (3 * AC_W)'(a_sq_s3) * (3 * AC_W)'(a_s3);
			t_s4        <= t_s3;
			t_sq_s4     <= (2 * TW)'(t_s3) * (2 * TW)'(t_s3);
			pos_s4      <= pos_s3;
			gt_half_s4  <= gt_half_s3;
			gt_one_s4   <= gt_one_s3;
			gt_3half_s4 <= gt_3half_s3;
			gt_two_s4   <= gt_two_s3;
			deg_s4      <= deg_s3;
			ord_s4      <= ord_s3;
			bad_s4      <= bad_s3;
		end
	end

	// stage 5: all results but the cubic value, rounded by shift; t cubed, inner cubic numerator
	logic signed [NW-1:0] a_n, asq_n, acu_n, tsq_n, d1_m, lin_n, q_n;
	logic                 use_div_c;

	always_comb begin
		a_n       = $signed(NW'(a_s4));
		asq_n     = $signed(NW'(a_sq_s4));
		acu_n     = $signed(NW'(a_cu_s4));
		tsq_n     = $signed(NW'(t_sq_s4));
		d1_m      = 3 * asq_n - (a_n <<< (F + 2));
		q_n       = (4 * ONECU_N + 3 * ONESQ_N - 6 * (asq_n <<< F) + 3 * acu_n)
		            >>> (2 * F + 1);
		lin_n     = '0;
		use_div_c = 1'b0;
		if (!bad_s4) begin
			case (deg_s4)
				DEG_HAAR: begin
					lin_n = gt_half_s4 ? '0 : ONE_N;
				end
				DEG_LINEAR: begin
					if (gt_one_s4)                lin_n = '0;
					else if (ord_s4 == ORD_VALUE) lin_n = ONE_N - a_n;
					else                          lin_n = pos_s4 ? -ONE_N : ONE_N;
				end
				DEG_QUAD: begin
					if (gt_3half_s4) begin
						lin_n = '0;
					end else begin
						case (ord_s4)
							ORD_VALUE: begin
								if (gt_half_s4) lin_n = (tsq_n + ONE_N) >>> (F + 1);
								else lin_n = (3 * ONESQ_N - (asq_n <<< 2) + (ONE_N <<< 1))
								             >>> (F + 2);
							end
							ORD_D1: begin
								if (gt_half_s4)
									lin_n = pos_s4 ? a_n - HALF3_N : HALF3_N - a_n;
								else
									lin_n = pos_s4 ? -(a_n <<< 1) : (a_n <<< 1);
							end
							default: lin_n = gt_half_s4 ? ONE_N : -(ONE_N <<< 1);
						endcase
					end
				end
				default: begin
					if (gt_two_s4) begin
						lin_n = '0;
					end else begin
						case (ord_s4)
							ORD_VALUE: use_div_c = 1'b1;
							ORD_D1: begin
								if (gt_one_s4)
									lin_n = (pos_s4 ? ONE_N - tsq_n : ONE_N + tsq_n) >>> (F + 1);
								else
									lin_n = ((pos_s4 ? d1_m : -d1_m) + ONE_N) >>> (F + 1);
							end
							default: lin_n = gt_one_s4 ? TWO_N - a_n : 3 * a_n - TWO_N;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s5     <= lin_n[RW-1:0];
			q_in_s5    <= q_n[QW-1:0];
			t_cu_s5    <= (3 * TW)'(t_sq_s4) * (3 * TW)'(t_s4);
			use_div_s5 <= use_div_c;
			gt_one_s5  <= gt_one_s4;
			deg_s5     <= deg_s4;
			bad_s5     <= bad_s4;
		end
	end

	// stage 6: pick the cubic numerator, already scaled down by two one-squared
	logic [NW-1:0] q_out_n;

	always_comb begin
		q_out_n = (NW'(t_cu_s5) + ONESQ_N * 3) >> (2 * F + 1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s6       <= gt_one_s5 ? q_out_n[QW-1:0] : q_in_s5;
			lin_s6     <= lin_s5;
			use_div_s6 <= use_div_s5;
			deg_s6     <= deg_s5;
			bad_s6     <= bad_s5;
		end
	end

	// stage 7: divide by three through the reciprocal
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s7    <= PW'(q_s6) * PW'(DIV3_M);
			lin_s7     <= lin_s6;
			use_div_s7 <= use_div_s6;
			deg_s7     <= deg_s6;
			bad_s7     <= bad_s6;
		end
	end

	// stage 8: output register, saturate to the result range
	logic signed [RW-1:0] val_c, sat_c;

	always_comb begin
		if (use_div_s7) val_c = $signed(RW'(prod_s7[PW-1:DK]));
		else            val_c = lin_s7;
		if (val_c > KV_MAX_R)      sat_c = KV_MAX_R;
		else if (val_c < KV_MIN_R) sat_c = KV_MIN_R;
		else                       sat_c = val_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kv_s8  <= sat_c[KV_W-1:0];
			sw_s8  <= {1'b0, deg_s7} + 3'd1;
			bad_s8 <= bad_s7;
		end
	end

	assign m_axis_tvalid = v_s8;
	assign m_axis_tdata  = {3'b000, sw_s8, kv_s8};
	assign m_axis_tuser  = bad_s8;

`ifndef SYNTHESIS
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[KV_W-1:0] == '0)
		else $error("undefined combination gave a nonzero value");

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2 == $past(v_s1) && v_s8 == $past(v_s7))
		else $error("valid bit lost or duplicated between stages");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s5) && $stable(lin_s5) && $stable(q_s6))
		else $error("pipeline moved during a stall");

	a_div_only_cubic: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && use_div_s7 |-> deg_s7 == DEG_CUBIC && !bad_s7)
		else $error("divide path used outside the cubic value");
`endif

endmodule
`default_nettype wire

>>> bench/tb_bspline_kernel_eval.sv
// Self-checking testbench for the B-spline kernel evaluator.
`timescale 1ns / 1ps
module tb_bspline_kernel_eval;
	import bske_pkg::*;

	localparam int FRAC = 16;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 50;
	localparam int SINK_HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [KV_W-1:0] kv;
		logic [SW_W-1:0] sw;
		logic            unsup;
	} kernel_res_t;

	typedef struct packed {
		logic [1:0]       deg;
		logic [1:0]       ord;
		logic [POS_W-1:0] pos;
		bit               typed;
		logic [KV_W-1:0]  kv;
		bit               unsup;
	} dir_row_t;

	localparam int N_DIR = 26;

	// typed values: 18'h10000 = +1.0, 18'h30000 = -1.0, 18'h20000 = -2.0
	dir_row_t dir_tab [N_DIR] = '{
		'{DEG_CUBIC,  ORD_VALUE, 20'd0,         1'b0, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_VALUE, 20'h7FFFF,     1'b1, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_VALUE, 20'h80000,     1'b1, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_VALUE, 20'd65536,     1'b0, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_VALUE, -20'sd131071,  1'b0, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_D1,    20'd0,         1'b0, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_D1,    20'd98304,     1'b0, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_D2,    20'd0,         1'b1, 18'h20000, 1'b0},
		'{DEG_CUBIC,  ORD_D2,    20'd131072,    1'b1, 18'h0,     1'b0},
		'{DEG_CUBIC,  ORD_NONE,  20'd1000,      1'b1, 18'h0,     1'b1},
		'{DEG_HAAR,   ORD_VALUE, 20'd32768,     1'b1, 18'h10000, 1'b0},
		'{DEG_HAAR,   ORD_VALUE, 20'd32769,     1'b1, 18'h0,     1'b0},
		'{DEG_HAAR,   ORD_VALUE, -20'sd32768,   1'b1, 18'h10000, 1'b0},
		'{DEG_HAAR,   ORD_D1,    20'd0,         1'b1, 18'h0,     1'b1},
		'{DEG_HAAR,   ORD_D2,    20'd100,       1'b1, 18'h0,     1'b1},
		'{DEG_LINEAR, ORD_VALUE, 20'd0,         1'b1, 18'h10000, 1'b0},
		'{DEG_LINEAR, ORD_D1,    20'd0,         1'b1, 18'h10000, 1'b0},
		'{DEG_LINEAR, ORD_D1,    20'd1,         1'b1, 18'h30000, 1'b0},
		'{DEG_LINEAR, ORD_D1,    -20'sd65536,   1'b1, 18'h10000, 1'b0},
		'{DEG_LINEAR, ORD_D1,    20'd65537,     1'b1, 18'h0,     1'b0},
		'{DEG_LINEAR, ORD_D2,    20'd5,         1'b1, 18'h0,     1'b1},
		'{DEG_QUAD,   ORD_VALUE, 20'd0,         1'b1, 18'd49152, 1'b0},
		'{DEG_QUAD,   ORD_D1,    20'd32768,     1'b0, 18'h0,     1'b0},
		'{DEG_QUAD,   ORD_D2,    20'd0,         1'b1, 18'h20000, 1'b0},
		'{DEG_QUAD,   ORD_D2,    20'd98304,     1'b1, 18'h10000, 1'b0},
		'{DEG_QUAD,   ORD_D2,    20'd98305,     1'b1, 18'h0,     1'b0}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_DEGREE;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [23:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [23:0]       m_axis_tdata;
	logic              m_axis_tuser;

	// predictor copy of the registers
	logic [1:0] cur_deg = DEG_RESET;
	logic [1:0] cur_ord = ORD_RESET;

	kernel_res_t pending_kernels [$];
	int n_positions = 0;
	int n_kernels = 0;
	int n_cfg_writes = 0;
	int n_mismatch = 0;
	bit quiet = 1'b0;
	bit sink_hold_req = 1'b0;
	bit [15:0] combos_seen = '0;

	bspline_kernel_eval #(.FRAC_BITS(FRAC)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	// floor(n/d + 1/2), d > 0
	function automatic longint round_half_up(longint n, longint d);
		longint num, den, q;
		num = 2 * n + d;
		den = 2 * d;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q--;
		return q;
	endfunction

	function automatic longint kernel_at(longint x, logic [1:0] deg, logic [1:0] ord);
		longint one, half, a, s, t, u, q1, r1, k, m, g;
		one = longint'(1) << FRAC;
		half = one >> 1;
		a = (x < 0) ? -x : x;
		s = (x > 0) ? 1 : -1;
		case (deg)
		DEG_HAAR: return (a > half) ? 0 : one;
		DEG_LINEAR: begin
			if (a > one) return 0;
			if (ord == ORD_VALUE) return one - a;
			return (x > 0) ? -one : one;
		end
		DEG_QUAD: begin
			if (a > 3 * half) return 0;
			if (ord == ORD_VALUE) begin
				if (a > half) begin
					t = 3 * half - a;
					return round_half_up(t * t, 2 * one);
				end
				return round_half_up(3 * one * one - 4 * a * a, 4 * one);
			end
			if (ord == ORD_D1) begin
				if (a > half) return (x > 0) ? a - 3 * half : 3 * half - a;
				return -2 * x;
			end
			return (a > half) ? one : -2 * one;
		end
		default: begin
			if (a > 2 * one) return 0;
			if (ord == ORD_VALUE) begin
				if (a > one) begin
					t = 2 * one - a;
					return round_half_up(t * t * t, 6 * one * one);
				end
				// 2/3 - a^2 (2 - a) / 2, split so the remainder rounds once
				u = a * a * (2 * one - a);
				q1 = u / (2 * one * one);
				r1 = u % (2 * one * one);
				k = (2 * one) / 3;
				m = (2 * one) % 3;
				g = 2 * m * one * one - 3 * r1;
				return k - q1 + round_half_up(g, 6 * one * one);
			end
			if (ord == ORD_D1) begin
				if (a > one) begin
					t = 2 * one - a;
					return round_half_up(-s * t * t, 2 * one);
				end
				return round_half_up(s * (3 * a * a - 4 * one * a), 2 * one);
			end
			if (a > one) return 2 * one - a;
			return 3 * a - 2 * one;
		end
		endcase
	endfunction

	function automatic kernel_res_t predict_kernel(logic [POS_W-1:0] pos);
		kernel_res_t r;
		longint x, v;
		bit bad;
		x = $signed(pos);
		bad = (cur_ord == ORD_NONE) || (cur_deg == DEG_HAAR && cur_ord != ORD_VALUE) ||
			(cur_deg == DEG_LINEAR && cur_ord == ORD_D2);
		v = 0;
		if (!bad) begin
			v = kernel_at(x, cur_deg, cur_ord);
			if (v > KV_MAX) v = KV_MAX;
			if (v < KV_MIN) v = KV_MIN;
		end
		r.kv = v[KV_W-1:0];
		r.sw = SW_W'(cur_deg) + 3'd1;
		r.unsup = bad;
		return r;
	endfunction

	function automatic logic [POS_W-1:0] random_position();
		int r, mag;
		r = $urandom_range(0, 99);
		if (r < 25)
			return POS_W'($urandom());
		if (r < 85)
			mag = $urandom_range(0, 163840);
		else
			mag = 32768 * $urandom_range(0, 4) + $urandom_range(0, 2) - 1;
		if ($urandom_range(0, 1))
			mag = -mag;
		return POS_W'(mag);
	endfunction

	// one transfer on the input side; stays valid for the caller to chain items
	task automatic send_position(input logic [POS_W-1:0] pos, input bit typed,
			input kernel_res_t typed_res);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, pos};
		do @(posedge clk); while (!s_axis_tready);
		pending_kernels.push_back(typed ? typed_res : predict_kernel(pos));
		n_positions++;
		combos_seen[{cur_deg, cur_ord}] = 1'b1;
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 99) < 10) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_kernels();
		s_axis_tvalid <= 1'b0;
		while (pending_kernels.size() != 0) @(posedge clk);
	endtask

	// call only with the block idle and the input side low
	task automatic write_config(input logic [1:0] deg, input logic [1:0] ord);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEGREE;
		cfg_data <= deg;
		@(posedge clk);
		cfg_index <= REG_ORDER;
		cfg_data <= ord;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_deg = deg;
		cur_ord = ord;
		n_cfg_writes += 2;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left = SINK_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 10) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		kernel_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kv = m_axis_tdata[17:0];
			got.sw = m_axis_tdata[20:18];
			got.unsup = m_axis_tuser;
			n_kernels++;
			if (pending_kernels.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("ERROR: unexpected transfer kv=%0d sw=%0d unsup=%0b",
						$signed(got.kv), got.sw, got.unsup);
			end else begin
				want = pending_kernels.pop_front();
				if (got.kv !== want.kv || got.sw !== want.sw || got.unsup !== want.unsup) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("ERROR: result %0d kv=%0d/%0d sw=%0d/%0d unsup=%0b/%0b (exp/got)",
							n_kernels, $signed(want.kv), $signed(got.kv), want.sw, got.sw,
							want.unsup, got.unsup);
				end
			end
		end
	end

	initial begin
		kernel_res_t typed_res;
		logic [1:0] deg, ord;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; rewrite registers whenever a row needs a new setting
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].deg != cur_deg || dir_tab[i].ord != cur_ord) begin
				drain_kernels();
				write_config(dir_tab[i].deg, dir_tab[i].ord);
			end
			typed_res.kv = dir_tab[i].kv;
			typed_res.sw = SW_W'(dir_tab[i].deg) + 3'd1;
			typed_res.unsup = dir_tab[i].unsup;
			send_position(dir_tab[i].pos, dir_tab[i].typed, typed_res);
			maybe_gap();
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain_kernels();
			case (p)
			0: begin deg = DEG_HAAR; ord = ORD_VALUE; end
			1: begin deg = DEG_CUBIC; ord = ORD_D2; end
			2: begin deg = DEG_CUBIC; ord = ORD_VALUE; end
			3: begin deg = DEG_QUAD; ord = ORD_NONE; end
			default: begin
				deg = 2'($urandom_range(0, 3));
				ord = ($urandom_range(0, 9) == 0) ? ORD_NONE : 2'($urandom_range(0, 2));
				// mostly keep to defined combinations
				if (((deg == DEG_HAAR && ord != ORD_VALUE) || (deg == DEG_LINEAR &&
						ord == ORD_D2)) && $urandom_range(0, 3) != 0)
					ord = ORD_VALUE;
			end
			endcase
			write_config(deg, ord);
			quiet = (p == 6);
			if (p == 2)
				sink_hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == PHASE_ITEMS / 2)
					drain_kernels();
				send_position(random_position(), 1'b0, typed_res);
				maybe_gap();
			end
			quiet = 1'b0;
		end

		drain_kernels();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run: %0d positions sent, %0d results checked, %0d register writes,",
			n_positions, n_kernels, n_cfg_writes);
		$display("     %0d of 16 degree/order settings exercised, %0d mismatches",
			$countones(combos_seen), n_mismatch);
		if (n_mismatch == 0 && pending_kernels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
